@@ rtl/rwasf_pkg.sv @@
package rwasf_pkg;

    localparam int ADDR_W = 6;
    localparam int APB_DW = 64;

    localparam logic [7:0] CH_NL       = 8'h0A;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        KIND_MATCH      = 2'd0,
        KIND_DONE       = 2'd1,
        KIND_INCOMPLETE = 2'd2,
        KIND_OVERFLOW   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_NEEDLE_LO  = 3'd0,
        REG_NEEDLE_HI  = 3'd1,
        REG_NEEDLE_LEN = 3'd2,
        REG_FOLD_CASE  = 3'd3,
        REG_FIRST_ROW  = 3'd4,
        REG_ROW_LIMIT  = 3'd5
    } reg_idx_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

@@ rtl/row_windowed_ascii_substring_finder.sv @@
// Channel   Dir   Beat contents
// s_*       in    tdata[7:0] text_byte; tlast last_byte
// m_*       out   tdata kind, match_row, match_start, match_end (low bit up); tlast final_res
// APB       in    needle_bytes_low/high, needle_length, fold_case, first_row, row_limit
//
// One text byte per cycle. A byte is latched in the input stage, then matched against
// the whole needle window combinationally and its results (up to two) pushed into a
// 4-entry result FIFO. Input stalls only while a byte waits in the input stage and
// the FIFO has fewer than two free slots.
// Results are written into the FIFO when the byte leaves the input stage.
// Reset clears stream state and registers; no clearing pass is needed.
module row_windowed_ascii_substring_finder #(
    parameter int NEEDLE_MAX = 16,
    parameter int COL_BITS   = 16,
    parameter int ROW_BITS   = 20
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    input  logic [7:0]                                     s_tdata,  // text_byte
    input  logic                                           s_tlast,  // last_byte
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // kind, match_row, match_start, match_end, zero pad
    output logic [((2+ROW_BITS+2*COL_BITS+7)/8)*8-1:0]     m_tdata,
    output logic                                           m_tlast,  // final_res
    input  logic                                           psel,
    input  logic                                           penable,
    input  logic                                           pwrite,
    input  logic [rwasf_pkg::ADDR_W-1:0]                   paddr,
    input  logic [rwasf_pkg::APB_DW-1:0]                   pwdata,
    output logic [rwasf_pkg::APB_DW-1:0]                   prdata,
    output logic                                           pready
);
    import rwasf_pkg::*;

    localparam int CW     = COL_BITS + 1;
    localparam int ELW    = $clog2(NEEDLE_MAX + 1);
    localparam int NB     = NEEDLE_MAX * 8;
    localparam int PAY_W  = 2 + ROW_BITS + 2 * COL_BITS;
    localparam int DATA_W = ((PAY_W + 7) / 8) * 8;
    localparam int ENT_W  = PAY_W + 1;
    localparam int DEPTH  = 4;
    localparam int PW     = $clog2(DEPTH);
    localparam int CNTW   = $clog2(DEPTH + 1);

    localparam logic [CW-1:0]       CNT_MAX = {CW{1'b1}};
    localparam logic [ROW_BITS-1:0] ROW_MAX = {ROW_BITS{1'b1}};

    // configuration
    logic [63:0]          nlo_reg, nhi_reg;
    logic [4:0]           nlen_reg;
    logic                 fold_reg;
    logic [ROW_BITS-1:0]  first_row_reg, row_limit_reg;
    logic                 wr_en;
    reg_idx_t             reg_idx;

    // derived needle view
    logic [NB-1:0]        needle_flat;
    logic [ELW-1:0]       eff_len_next, eff_len_reg;
    logic                 ascii_next, ascii_reg;
    logic [NB-1:0]        pat_next, pat_reg;
    logic [NEEDLE_MAX-1:0] mask_next, mask_reg;

    // stream state
    logic [NB-1:0]        recent_reg, recent_next;
    logic [CW-1:0]        col_reg, col_next, col_inc;
    logic [CW-1:0]        nas_reg, nas_next;
    logic [ROW_BITS-1:0]  src_reg, src_next, srch_reg, srch_next;
    logic                 nul_reg, nul_next;
    logic                 stopped_reg, stopped_next;
    kind_t                aborted_reg, aborted_next;

    // input stage
    logic                 stage_valid_reg, stage_valid_next;
    logic [7:0]           stage_byte_reg;
    logic                 stage_last_reg;

    // processing
    logic [7:0]           b;
    logic                 adv, room, is_sep, take, close_row, in_window, searching, hit;
    logic [NEEDLE_MAX-1:0] eq;
    logic                 match_push, done_push;
    logic [COL_BITS-1:0]  m_start, m_end;
    kind_t                done_kind;
    logic [ENT_W-1:0]     match_ent, done_ent;

    // result FIFO
    logic [ENT_W-1:0]     fifo_mem [DEPTH];
    logic [PW-1:0]        wptr_reg, rptr_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic                 pop;
    logic [1:0]           push_n;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nlo_reg       <= '0;
            nhi_reg       <= '0;
            nlen_reg      <= '0;
            fold_reg      <= 1'b0;
            first_row_reg <= '0;
            row_limit_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_NEEDLE_LO:  nlo_reg       <= pwdata;
                REG_NEEDLE_HI:  nhi_reg       <= pwdata;
                REG_NEEDLE_LEN: nlen_reg      <= pwdata[4:0];
                REG_FOLD_CASE:  fold_reg      <= pwdata[0];
                REG_FIRST_ROW:  first_row_reg <= pwdata[ROW_BITS-1:0];
                REG_ROW_LIMIT:  row_limit_reg <= pwdata[ROW_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_NEEDLE_LO:  prdata = nlo_reg;
            REG_NEEDLE_HI:  prdata = nhi_reg;
            REG_NEEDLE_LEN: prdata = APB_DW'(nlen_reg);
            REG_FOLD_CASE:  prdata = APB_DW'(fold_reg);
            REG_FIRST_ROW:  prdata = APB_DW'(first_row_reg);
            REG_ROW_LIMIT:  prdata = APB_DW'(row_limit_reg);
            default:        prdata = '0;
        endcase
    end

    // needle right-aligned against the byte history, recomputed after each write
    always_comb
    begin
        for (int i = 0; i < NEEDLE_MAX; i++)
        begin
            needle_flat[8*i +: 8] = 8'({nhi_reg, nlo_reg} >> (8 * i));
        end
        if (int'(nlen_reg) > NEEDLE_MAX)
        begin
            eff_len_next = ELW'(NEEDLE_MAX);
        end
        else
        begin
            eff_len_next = ELW'(nlen_reg);
        end
        ascii_next = 1'b1;
        pat_next   = '0;
        mask_next  = '0;
        for (int k = 0; k < NEEDLE_MAX; k++)
        begin
            if (k < int'(eff_len_next))
            begin
                if (needle_flat[8*k+7])
                begin
                    ascii_next = 1'b0;
                end
                pat_next[8*k +: 8] = fold_char(
                    8'(needle_flat >> (8 * (int'(eff_len_next) - 1 - k))), fold_reg);
                mask_next[k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_len_reg <= '0;
            ascii_reg   <= 1'b1;
            pat_reg     <= '0;
            mask_reg    <= '0;
        end
        else
        begin
            eff_len_reg <= eff_len_next;
            ascii_reg   <= ascii_next;
            pat_reg     <= pat_next;
            mask_reg    <= mask_next;
        end
    end

    // input stage
    assign room     = (cnt_reg <= CNTW'(DEPTH - 2));
    assign adv      = stage_valid_reg && room;
    assign s_tready = !stage_valid_reg || room;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (s_tvalid && s_tready)
        begin
            stage_valid_next = 1'b1;
        end
        else if (adv)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            stage_byte_reg <= s_tdata;
            stage_last_reg <= s_tlast;
        end
    end

    // byte processing
    always_comb
    begin
        b         = stage_byte_reg;
        is_sep    = (b == CH_NL) || (b == CH_NUL);
        take      = !stopped_reg && !is_sep;
        close_row = !stopped_reg && !nul_reg && is_sep;
        searching = (eff_len_reg != '0) && ascii_reg;
        in_window = (src_reg >= first_row_reg) &&
                    ((row_limit_reg == '0) || (srch_reg < row_limit_reg));
        col_inc   = (col_reg == CNT_MAX) ? col_reg : col_reg + CW'(1);

        recent_next  = recent_reg;
        col_next     = col_reg;
        nas_next     = nas_reg;
        src_next     = src_reg;
        srch_next    = srch_reg;
        nul_next     = nul_reg;
        stopped_next = stopped_reg;
        aborted_next = aborted_reg;
        match_push   = 1'b0;

        recent_next = NB'({recent_reg, b});
        for (int k = 0; k < NEEDLE_MAX; k++)
        begin
            eq[k] = (fold_char(recent_next[8*k +: 8], fold_reg) == pat_reg[8*k +: 8]);
        end
        hit     = &(eq | ~mask_reg);
        m_start = COL_BITS'(col_inc - CW'(eff_len_reg));
        m_end   = col_inc[COL_BITS-1:0];

        if (!stopped_reg)
        begin
            nul_next = (b == CH_NUL);
        end

        if (take)
        begin
            col_next = col_inc;
            if (searching && in_window)
            begin
                if (b[7])
                begin
                    aborted_next = KIND_INCOMPLETE;
                    stopped_next = 1'b1;
                end
                else if (({1'b0, col_inc} >= ({1'b0, nas_reg} + (CW+1)'(eff_len_reg)))
                         && hit)
                begin
                    if (col_inc[CW-1])
                    begin
                        aborted_next = KIND_OVERFLOW;
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        nas_next   = col_inc;
                        match_push = 1'b1;
                    end
                end
            end
        end
        else
        begin
            recent_next = recent_reg;
        end

        if (close_row)
        begin
            if (in_window && srch_reg != ROW_MAX)
            begin
                srch_next = srch_reg + ROW_BITS'(1);
            end
            if (src_reg != ROW_MAX)
            begin
                src_next = src_reg + ROW_BITS'(1);
            end
            if (row_limit_reg != '0 && srch_next >= row_limit_reg)
            begin
                stopped_next = 1'b1;
            end
            col_next = '0;
            nas_next = '0;
        end

        done_push = stage_last_reg;
        if (eff_len_reg == '0)
        begin
            done_kind = KIND_DONE;
        end
        else if (!ascii_reg)
        begin
            done_kind = KIND_INCOMPLETE;
        end
        else if (aborted_next != KIND_MATCH)
        begin
            done_kind = aborted_next;
        end
        else
        begin
            done_kind = KIND_DONE;
        end

        match_ent = {1'b0, m_end, m_start, srch_reg, KIND_MATCH};
        done_ent  = {1'b1, {(PAY_W-2){1'b0}}, done_kind};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg  <= '0;
            col_reg     <= '0;
            nas_reg     <= '0;
            src_reg     <= '0;
            srch_reg    <= '0;
            nul_reg     <= 1'b0;
            stopped_reg <= 1'b0;
            aborted_reg <= KIND_MATCH;
        end
        else if (adv)
        begin
            if (stage_last_reg)
            begin
                recent_reg  <= '0;
                col_reg     <= '0;
                nas_reg     <= '0;
                src_reg     <= '0;
                srch_reg    <= '0;
                nul_reg     <= 1'b0;
                stopped_reg <= 1'b0;
                aborted_reg <= KIND_MATCH;
            end
            else
            begin
                recent_reg  <= recent_next;
                col_reg     <= col_next;
                nas_reg     <= nas_next;
                src_reg     <= src_next;
                srch_reg    <= srch_next;
                nul_reg     <= nul_next;
                stopped_reg <= stopped_next;
                aborted_reg <= aborted_next;
            end
        end
    end

    // result FIFO, match beat ahead of done beat
    assign pop      = m_tvalid && m_tready;
    assign push_n   = adv ? (2'(match_push) + 2'(done_push)) : 2'd0;
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = DATA_W'(fifo_mem[rptr_reg][PAY_W-1:0]);
    assign m_tlast  = fifo_mem[rptr_reg][PAY_W];

    always_ff @(posedge clk)
    begin
        if (adv && match_push)
        begin
            fifo_mem[wptr_reg] <= match_ent;
            if (done_push)
            begin
                fifo_mem[wptr_reg + PW'(1)] <= done_ent;
            end
        end
        else if (adv && done_push)
        begin
            fifo_mem[wptr_reg] <= done_ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_reg + PW'(push_n);
            if (pop)
            begin
                rptr_reg <= rptr_reg + PW'(1);
            end
            cnt_reg <= cnt_reg + CNTW'(push_n) - CNTW'(pop);
        end
    end

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(DEPTH))
        else $error("result FIFO over capacity");

    a_no_match_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && stopped_reg) |-> !match_push)
        else $error("match pushed after search stopped");

    a_match_span: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && match_push) |-> (m_end > m_start))
        else $error("match end not past start");

    a_stream_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && stage_last_reg) |=> (col_reg == '0 && !stopped_reg && srch_reg == '0))
        else $error("stream state not cleared after last beat");

endmodule

@@ tb/row_windowed_ascii_substring_finder_tb.sv @@
module row_windowed_ascii_substring_finder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rwasf_pkg::*;

    localparam int NEEDLE_MAX = 16;
    localparam int COL_BITS   = 16;
    localparam int ROW_BITS   = 20;
    localparam int RES_W      = ((2 + ROW_BITS + 2 * COL_BITS + 7) / 8) * 8;
    localparam int unsigned COL_MAX = (1 << COL_BITS) - 1;
    localparam int unsigned COL_SAT = 2 * COL_MAX + 1;
    localparam int unsigned ROW_MAX = (1 << ROW_BITS) - 1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_beat_t;

    typedef struct packed {
        kind_t               kind;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] start_col;
        logic [COL_BITS-1:0] end_col;
        logic                fin;
    } finder_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = 8'h00;      // text_byte
    logic              s_tlast = 1'b0;       // last_byte
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // kind, match_row, match_start, match_end, zero pad
    logic [RES_W-1:0]  m_tdata;
    logic              m_tlast;              // final_res
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    row_windowed_ascii_substring_finder #(
        .NEEDLE_MAX(NEEDLE_MAX),
        .COL_BITS(COL_BITS),
        .ROW_BITS(ROW_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // finder state as seen from outside
    logic [63:0]         cfg_needle_lo = '0;
    logic [63:0]         cfg_needle_hi = '0;
    logic [4:0]          cfg_len = '0;
    logic                cfg_fold = 1'b0;
    logic [ROW_BITS-1:0] cfg_first_row = '0;
    logic [ROW_BITS-1:0] cfg_row_limit = '0;

    logic [7:0]  window_bytes [NEEDLE_MAX];
    int unsigned col_count;
    int unsigned next_start;
    int unsigned src_rows;
    int unsigned searched_rows;
    bit          nul_run;
    bit          halted;
    bit          aborted;
    kind_t       abort_kind;

    text_beat_t     text_beats[$];
    finder_result_t pending_results[$];

    logic beat_taken = 1'b0;
    bit   sender_busy = 1'b0;
    int   burst_left = 1;
    int   gap_left = 0;
    int   stall_left = 0;
    int   stall_mode = 0;
    int   bytes_queued = 0;
    int   match_count = 0;
    int   done_count = 0;
    int   mismatches = 0;

    function automatic void clear_stream();
        foreach (window_bytes[k])
            window_bytes[k] = 8'h00;
        col_count = 0;
        next_start = 0;
        src_rows = 0;
        searched_rows = 0;
        nul_run = 1'b0;
        halted = 1'b0;
        aborted = 1'b0;
        abort_kind = KIND_MATCH;
    endfunction

    function automatic logic [7:0] needle_char(int i);
        if (i < 8)
            return cfg_needle_lo[8*i +: 8];
        if (i < 16)
            return cfg_needle_hi[8*(i-8) +: 8];
        return 8'h00;
    endfunction

    function automatic logic [7:0] lower(logic [7:0] c);
        if (cfg_fold && c >= CH_UPPER_A && c <= CH_UPPER_Z)
            return c + CASE_OFFSET;
        return c;
    endfunction

    function automatic bit row_searchable();
        return src_rows >= cfg_first_row &&
               (cfg_row_limit == 0 || searched_rows < cfg_row_limit);
    endfunction

    function automatic void close_row();
        if (row_searchable() && searched_rows < ROW_MAX)
            searched_rows++;
        if (src_rows < ROW_MAX)
            src_rows++;
        if (cfg_row_limit != 0 && searched_rows >= cfg_row_limit)
            halted = 1'b1;
        col_count = 0;
        next_start = 0;
    endfunction

    function automatic void advance_column(logic [7:0] b, int unsigned len, bit searching);
        int unsigned start;
        for (int k = NEEDLE_MAX - 1; k > 0; k--)
            window_bytes[k] = window_bytes[k-1];
        window_bytes[0] = b;
        if (col_count < COL_SAT)
            col_count++;
        if (!searching || !row_searchable())
            return;
        if (b[7])
        begin
            aborted = 1'b1;
            abort_kind = KIND_INCOMPLETE;
            halted = 1'b1;
            return;
        end
        if (col_count < len)
            return;
        start = col_count - len;
        if (start < next_start)
            return;
        for (int k = 0; k < len; k++)
            if (lower(window_bytes[k]) != lower(needle_char(len - 1 - k)))
                return;
        if (col_count > COL_MAX)
        begin
            aborted = 1'b1;
            abort_kind = KIND_OVERFLOW;
            halted = 1'b1;
            return;
        end
        next_start = col_count;
        pending_results.push_back({KIND_MATCH, ROW_BITS'(searched_rows), COL_BITS'(start),
                                   COL_BITS'(col_count), 1'b0});
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic last);
        int unsigned len;
        bit          ascii;
        bit          searching;
        kind_t       status;
        len = (cfg_len > NEEDLE_MAX) ? NEEDLE_MAX : cfg_len;
        ascii = 1'b1;
        for (int i = 0; i < len; i++)
            if (needle_char(i) >= 8'h80)
                ascii = 1'b0;
        searching = len != 0 && ascii;
        if (!halted)
        begin
            if (nul_run)
            begin
                if (b == CH_NL)
                    nul_run = 1'b0;
                else if (b != CH_NUL)
                begin
                    nul_run = 1'b0;
                    advance_column(b, len, searching);
                end
            end
            else if (b == CH_NL || b == CH_NUL)
            begin
                close_row();
                if (b == CH_NUL)
                    nul_run = 1'b1;
            end
            else
                advance_column(b, len, searching);
        end
        if (last)
        begin
            if (len == 0)
                status = KIND_DONE;
            else if (!ascii)
                status = KIND_INCOMPLETE;
            else if (aborted)
                status = abort_kind;
            else
                status = KIND_DONE;
            pending_results.push_back({status, ROW_BITS'(0), COL_BITS'(0), COL_BITS'(0), 1'b1});
            clear_stream();
        end
    endfunction

    function automatic void report_mismatch(string what, finder_result_t want,
                                            finder_result_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t %s: expected kind=%0d row=%0d start=%0d end=%0d fin=%0d",
                     $realtime, what, want.kind, want.row, want.start_col, want.end_col,
                     want.fin);
            $display("    actual kind=%0d row=%0d start=%0d end=%0d fin=%0d",
                     got.kind, got.row, got.start_col, got.end_col, got.fin);
        end
    endfunction

    function automatic void check_result(finder_result_t got);
        finder_result_t want;
        if (got.kind == KIND_MATCH)
            match_count++;
        else
            done_count++;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result", '0, got);
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.row !== want.row || got.start_col !== want.start_col
            || got.end_col !== want.end_col || got.fin !== want.fin)
            report_mismatch("result mismatch", want, got);
    endfunction

    function automatic void queue_byte(logic [7:0] b, logic last);
        text_beats.push_back({b, last});
        bytes_queued++;
    endfunction

    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], 1'b0);
    endfunction

    function automatic logic [7:0] text_letter();
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(1, 127));
            1, 2: return "A";
            3, 4: return "B";
            5, 6: return "b";
            default: return "a";
        endcase
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_NEEDLE_LO:  cfg_needle_lo = value;
            REG_NEEDLE_HI:  cfg_needle_hi = value;
            REG_NEEDLE_LEN: cfg_len = value[4:0];
            REG_FOLD_CASE:  cfg_fold = value[0];
            REG_FIRST_ROW:  cfg_first_row = value[ROW_BITS-1:0];
            REG_ROW_LIMIT:  cfg_row_limit = value[ROW_BITS-1:0];
            default: ;
        endcase
    endtask

    // wait for the sender to empty, then for every expected beat, then settle
    task automatic drain_results();
        int guard;
        guard = 0;
        while (text_beats.size() != 0 || sender_busy)
            @(negedge clk);
        while (pending_results.size() != 0 && guard < 4000)
        begin
            @(negedge clk);
            guard++;
        end
        if (pending_results.size() != 0)
        begin
            mismatches += pending_results.size();
            $display("%0t %0d expected results never arrived", $realtime,
                     pending_results.size());
            pending_results.delete();
        end
        repeat (10) @(negedge clk);
    endtask

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            beat_taken <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_result({kind_t'(m_tdata[1:0]), m_tdata[2 +: ROW_BITS],
                              m_tdata[2+ROW_BITS +: COL_BITS],
                              m_tdata[2+ROW_BITS+COL_BITS +: COL_BITS], m_tlast});
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tlast);
            beat_taken <= s_tvalid && s_tready;
        end
    end

    // sender: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        text_beat_t beat;
        if (rst_n && (!s_tvalid || beat_taken))
        begin
            if (gap_left == 0 && text_beats.size() != 0)
            begin
                beat = text_beats.pop_front();
                sender_busy = 1'b1;
                s_tdata <= beat.data;
                s_tlast <= beat.last;
                s_tvalid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
            else
            begin
                if (gap_left != 0)
                    gap_left--;
                sender_busy = 1'b0;
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stretches of full readiness, random stalls and heavy back-pressure
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(5, 40);
        end
        stall_left--;
        case (stall_mode)
            0, 1: m_tready <= 1'b1;
            2: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    initial
    begin
        #30ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int         r;
        int         nlen;
        int         eff;
        int         row_len;
        int         n;
        int         phase_start;
        bit         paused;
        logic [7:0] ndl [NEEDLE_MAX];
        logic [63:0] lo;
        logic [63:0] hi;
        logic       fold;
        logic [7:0] c;

        paused = 1'b0;
        clear_stream();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // skipped leading row, case folding, NUL run with newline, row limit
        write_reg(REG_NEEDLE_LO, 64'h6241);
        write_reg(REG_NEEDLE_HI, 64'h0);
        write_reg(REG_NEEDLE_LEN, 64'd2);
        write_reg(REG_FOLD_CASE, 64'd1);
        write_reg(REG_FIRST_ROW, 64'd1);
        write_reg(REG_ROW_LIMIT, 64'd2);
        queue_text("ab");
        queue_byte(CH_NL, 1'b0);
        queue_text("xaBab");
        queue_byte(CH_NUL, 1'b0);
        queue_byte(CH_NUL, 1'b0);
        queue_byte(CH_NL, 1'b0);
        queue_text("aAb");
        queue_byte(CH_NL, 1'b0);
        queue_byte(8'hC8, 1'b1);
        drain_results();

        // exact case, then a non-ASCII byte in a searched row
        write_reg(REG_FOLD_CASE, 64'd0);
        write_reg(REG_FIRST_ROW, 64'd0);
        write_reg(REG_ROW_LIMIT, 64'd0);
        write_reg(REG_NEEDLE_LO, 64'h6261);
        queue_text("Aab");
        queue_byte(8'hFF, 1'b0);
        queue_byte("a", 1'b0);
        queue_byte("b", 1'b1);
        drain_results();

        // empty needle with register extremes
        write_reg(REG_NEEDLE_LO, '1);
        write_reg(REG_NEEDLE_LEN, 64'd0);
        write_reg(REG_FIRST_ROW, 64'hFFFFF);
        write_reg(REG_ROW_LIMIT, 64'hFFFFF);
        queue_byte("a", 1'b1);
        drain_results();

        // oversized length clamps to 16, needle not ASCII
        write_reg(REG_NEEDLE_LEN, 64'd31);
        write_reg(REG_NEEDLE_HI, '1);
        queue_byte("x", 1'b1);
        drain_results();

        for (int ph = 0; ph < 8; ph++)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                nlen = $urandom_range(1, 3);
            else if (r < 8)
                nlen = $urandom_range(4, 8);
            else if (r == 8)
                nlen = NEEDLE_MAX;
            else
                nlen = $urandom_range(17, 31);
            eff = (nlen > NEEDLE_MAX) ? NEEDLE_MAX : nlen;
            for (int i = 0; i < NEEDLE_MAX; i++)
                ndl[i] = (i < eff) ? text_letter() : 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0)
                ndl[$urandom_range(0, eff - 1)] = 8'($urandom_range(128, 255));
            for (int i = 0; i < 8; i++)
            begin
                lo[8*i +: 8] = ndl[i];
                hi[8*i +: 8] = ndl[i+8];
            end
            fold = 1'($urandom_range(0, 1));
            write_reg(REG_NEEDLE_LO, lo);
            write_reg(REG_NEEDLE_HI, hi);
            write_reg(REG_NEEDLE_LEN, 64'(nlen));
            write_reg(REG_FOLD_CASE, 64'(fold));
            write_reg(REG_FIRST_ROW, 64'($urandom_range(0, 2)));
            write_reg(REG_ROW_LIMIT, 64'($urandom_range(0, 4)));

            phase_start = bytes_queued;
            while (bytes_queued - phase_start < 100)
            begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 30)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
                else
                    repeat ($urandom_range(1, 6))
                    begin
                        row_len = $urandom_range(0, 24);
                        n = 0;
                        while (n < row_len)
                        begin
                            r = $urandom_range(0, 99);
                            if (r < 30)
                            begin
                                for (int i = 0; i < eff; i++)
                                begin
                                    c = ndl[i];
                                    if (fold && (c | CASE_OFFSET) >= (CH_UPPER_A | CASE_OFFSET)
                                        && (c | CASE_OFFSET) <= (CH_UPPER_Z | CASE_OFFSET)
                                        && $urandom_range(0, 1) == 1)
                                        c = c ^ CASE_OFFSET;
                                    queue_byte(c, 1'b0);
                                end
                                n += eff;
                            end
                            else if (r < 34)
                            begin
                                queue_byte(8'($urandom_range(0, 255)), 1'b0);
                                n++;
                            end
                            else if (r < 35)
                            begin
                                queue_byte(8'($urandom_range(128, 255)), 1'b0);
                                n++;
                            end
                            else
                            begin
                                queue_byte(text_letter(), 1'b0);
                                n++;
                            end
                        end
                        case ($urandom_range(0, 4))
                            0, 1: queue_byte(CH_NL, 1'b0);
                            2: queue_byte(CH_NUL, 1'b0);
                            3:
                            begin
                                queue_byte(CH_NUL, 1'b0);
                                queue_byte(CH_NUL, 1'b0);
                                queue_byte(CH_NL, 1'b0);
                            end
                            default:
                            begin
                                queue_byte(CH_NUL, 1'b0);
                                queue_byte(CH_NL, 1'b0);
                            end
                        endcase
                    end
                // closing beat; sometimes it completes a match as well
                case ($urandom_range(0, 5))
                    0: queue_byte(text_letter(), 1'b1);
                    1: queue_byte(CH_NL, 1'b1);
                    2: queue_byte(CH_NUL, 1'b1);
                    3: queue_byte(8'($urandom_range(0, 255)), 1'b1);
                    default:
                    begin
                        for (int i = 0; i < eff; i++)
                            queue_byte(ndl[i], i == eff - 1);
                    end
                endcase
                if (ph == 3 && !paused && bytes_queued - phase_start >= 60)
                begin
                    drain_results();
                    paused = 1'b1;
                end
            end
            drain_results();
        end

        $display("Sent %0d text bytes across 12 needle setups (folding, row windows).",
                 bytes_queued);
        $display("Checked %0d match beats and %0d done beats.", match_count, done_count);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
